### hdl/lodd_pkg.sv
// ----------------------------------------------------------------------------
// lodd_pkg
// shared types and codes for the lock order deadlock detector
// ----------------------------------------------------------------------------
package lodd_pkg;

  localparam int OP_W = 5;

  localparam logic [OP_W-1:0] OP_IDLE   = 5'd0;
  localparam logic [OP_W-1:0] OP_T_RD   = 5'd1;
  localparam logic [OP_W-1:0] OP_T_CMP  = 5'd2;
  localparam logic [OP_W-1:0] OP_ALLOC  = 5'd3;
  localparam logic [OP_W-1:0] OP_C_RD   = 5'd4;
  localparam logic [OP_W-1:0] OP_C_LD   = 5'd5;
  localparam logic [OP_W-1:0] OP_L_HRD  = 5'd6;
  localparam logic [OP_W-1:0] OP_L_HLD  = 5'd7;
  localparam logic [OP_W-1:0] OP_E_RD   = 5'd8;
  localparam logic [OP_W-1:0] OP_E_CMP  = 5'd9;
  localparam logic [OP_W-1:0] OP_E_ADD  = 5'd10;
  localparam logic [OP_W-1:0] OP_P_INIT = 5'd11;
  localparam logic [OP_W-1:0] OP_P_PASS = 5'd12;
  localparam logic [OP_W-1:0] OP_P_J    = 5'd13;
  localparam logic [OP_W-1:0] OP_P_JLD  = 5'd14;
  localparam logic [OP_W-1:0] OP_P_IRD  = 5'd15;
  localparam logic [OP_W-1:0] OP_P_ICMP = 5'd16;
  localparam logic [OP_W-1:0] OP_APPEND = 5'd17;
  localparam logic [OP_W-1:0] OP_U_HRD  = 5'd18;
  localparam logic [OP_W-1:0] OP_U_HCMP = 5'd19;
  localparam logic [OP_W-1:0] OP_U_ERD  = 5'd20;
  localparam logic [OP_W-1:0] OP_U_ECMP = 5'd21;
  localparam logic [OP_W-1:0] OP_FIN    = 5'd22;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_THR_FULL  = 2'd1;
  localparam logic [1:0] ST_EDGE_FULL = 2'd2;
  localparam logic [1:0] ST_HELD_FULL = 2'd3;

  localparam logic REQ_LOCK   = 1'b0;
  localparam logic REQ_UNLOCK = 1'b1;

  typedef struct packed {
    logic [OP_W-1:0] op;
  } lodd_cmd_t;

  typedef struct packed {
    logic t_lt;
    logic t_hit;
    logic slots_full;
    logic h_lt;
    logic h_self;
    logic e_lt;
    logic e_dup;
    logic pass_go;
    logic j_lt;
    logic gone_j;
    logic gone_k;
    logic t_in;
    logic kind;
    logic out_free;
  } lodd_sts_t;

endpackage

### hdl/lock_order_deadlock_detector_top.sv
// ----------------------------------------------------------------------------
// lock_order_deadlock_detector_top
// lock order graph deadlock detector, one result per request
// ----------------------------------------------------------------------------
// Each request (lock or unlock by a thread) is handled alone and yields one
// result. A request takes a variable number of cycles, since every table
// sits in a single read port memory with a registered read: a thread lookup,
// then for a lock an edge insertion for each held lock plus the cycle check,
// which walks the edge table pass after pass, and for an unlock a walk over
// the held list and the edge table. A finished result is held in the output
// register while the next request is taken. No clearing pass is needed after
// reset.
module lock_order_deadlock_detector_top
  import lodd_pkg::*;
#(
  parameter int MAX_THREADS = 16,
  parameter int MAX_HELD    = 64,
  parameter int MAX_EDGES   = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // thread_id, lock_id
  input  logic        in_tuser,   // req_type
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // deadlock, status, edge_total, zero fill
);

  lodd_cmd_t cmd;
  lodd_sts_t sts;

  assign in_tready = cmd.op == OP_IDLE;

  lodd_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .sts(sts), .cmd(cmd)
  );

  lodd_dp #(
    .MAX_THREADS(MAX_THREADS), .MAX_HELD(MAX_HELD), .MAX_EDGES(MAX_EDGES)
  ) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .in_tvalid(in_tvalid),
    .in_tdata(in_tdata), .in_tuser(in_tuser), .out_tready(out_tready),
    .sts(sts), .out_tvalid(out_tvalid), .out_tdata(out_tdata)
  );

endmodule

### hdl/lodd_ram.sv
// ----------------------------------------------------------------------------
// lodd_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
module lodd_ram #(
  parameter int W = 32,
  parameter int D = 16,
  localparam int AW = (D > 1) ? $clog2(D) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hdl/lodd_ctrl.sv
// ----------------------------------------------------------------------------
// lodd_ctrl
// sequencing state machine, issues one datapath command per cycle
// ----------------------------------------------------------------------------
module lodd_ctrl
  import lodd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  input  lodd_sts_t  sts,
  output lodd_cmd_t  cmd
);

  logic [OP_W-1:0] state_r;
  logic [OP_W-1:0] state_nxt;

  assign cmd.op = state_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      OP_IDLE:   if (in_tvalid) state_nxt = OP_T_RD;
      OP_T_RD: begin
        if (sts.t_lt) state_nxt = OP_T_CMP;
        else if (sts.slots_full) state_nxt = OP_FIN;
        else state_nxt = OP_ALLOC;
      end
      OP_T_CMP:  state_nxt = sts.t_hit ? OP_C_RD : OP_T_RD;
      OP_ALLOC:  state_nxt = (sts.kind == REQ_UNLOCK) ? OP_U_HRD : OP_L_HRD;
      OP_C_RD:   state_nxt = OP_C_LD;
      OP_C_LD:   state_nxt = (sts.kind == REQ_UNLOCK) ? OP_U_HRD : OP_L_HRD;
      OP_L_HRD:  state_nxt = sts.h_lt ? OP_L_HLD : OP_P_INIT;
      OP_L_HLD:  state_nxt = sts.h_self ? OP_L_HRD : OP_E_RD;
      OP_E_RD:   state_nxt = sts.e_lt ? OP_E_CMP : OP_E_ADD;
      OP_E_CMP:  state_nxt = sts.e_dup ? OP_L_HRD : OP_E_RD;
      OP_E_ADD:  state_nxt = OP_L_HRD;
      OP_P_INIT: state_nxt = OP_P_PASS;
      OP_P_PASS: state_nxt = sts.pass_go ? OP_P_J : OP_APPEND;
      OP_P_J: begin
        if (!sts.j_lt) state_nxt = OP_P_PASS;
        else if (!sts.gone_j) state_nxt = OP_P_JLD;
      end
      OP_P_JLD:  state_nxt = OP_P_IRD;
      OP_P_IRD: begin
        if (!sts.e_lt) state_nxt = OP_P_J;
        else if (!sts.gone_k) state_nxt = OP_P_ICMP;
      end
      OP_P_ICMP: state_nxt = sts.t_in ? OP_P_J : OP_P_IRD;
      OP_APPEND: state_nxt = OP_FIN;
      OP_U_HRD:  state_nxt = sts.h_lt ? OP_U_HCMP : OP_U_ERD;
      OP_U_HCMP: state_nxt = OP_U_HRD;
      OP_U_ERD:  state_nxt = sts.e_lt ? OP_U_ECMP : OP_FIN;
      OP_U_ECMP: state_nxt = OP_U_ERD;
      OP_FIN:    if (sts.out_free) state_nxt = OP_IDLE;
      default:   state_nxt = OP_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= OP_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

### hdl/lodd_dp.sv
// ----------------------------------------------------------------------------
// lodd_dp
// thread, held list and edge tables with their counters and result register
// ----------------------------------------------------------------------------
module lodd_dp
  import lodd_pkg::*;
#(
  parameter int MAX_THREADS = 16,
  parameter int MAX_HELD    = 64,
  parameter int MAX_EDGES   = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  lodd_cmd_t   cmd,
  input  logic        in_tvalid,
  input  logic [63:0] in_tdata,
  input  logic        in_tuser,
  input  logic        out_tready,
  output lodd_sts_t   sts,
  output logic        out_tvalid,
  output logic [15:0] out_tdata
);

  localparam int TAW = (MAX_THREADS > 1) ? $clog2(MAX_THREADS) : 1;
  localparam int TCW = $clog2(MAX_THREADS + 1);
  localparam int HCW = $clog2(MAX_HELD + 1);
  localparam int HAW = (MAX_THREADS * MAX_HELD > 1) ? $clog2(MAX_THREADS * MAX_HELD) : 1;
  localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int ECW = $clog2(MAX_EDGES + 1);

  logic            kind_r;
  logic [31:0]     tid_r;
  logic [31:0]     lid_r;
  logic [31:0]     src_r;
  logic [TCW-1:0]  t_r;
  logic [TCW-1:0]  slots_used_r;
  logic [TAW-1:0]  slot_r;
  logic [HCW-1:0]  cnt_r;
  logic [HCW-1:0]  i_r;
  logic [HCW-1:0]  hkeep_r;
  logic [ECW-1:0]  k_r;
  logic [ECW-1:0]  j_r;
  logic [ECW-1:0]  ekeep_r;
  logic [ECW-1:0]  eu_r;
  logic [ECW-1:0]  left_r;
  logic            changed_r;
  logic [MAX_EDGES-1:0] gone_r;
  logic [1:0]      status_r;
  logic            deadlock_r;
  logic            out_valid_r;
  logic [15:0]     out_data_r;

  logic            thr_we;
  logic [TAW-1:0]  thr_waddr;
  logic [31:0]     thr_rdata;
  logic            cnt_we;
  logic [TAW-1:0]  cnt_waddr;
  logic [HCW-1:0]  cnt_wdata;
  logic [HCW-1:0]  cnt_rdata;
  logic            held_we;
  logic [HAW-1:0]  held_base;
  logic [HAW-1:0]  held_waddr;
  logic [31:0]     held_wdata;
  logic [HAW-1:0]  held_raddr;
  logic [31:0]     held_rdata;
  logic            edge_we;
  logic [EAW-1:0]  edge_waddr;
  logic [31:0]     esrc_wdata;
  logic [31:0]     etgt_wdata;
  logic [EAW-1:0]  esrc_raddr;
  logic [31:0]     esrc_rdata;
  logic [31:0]     etgt_rdata;
  logic            out_free;
  logic            e_keep;

  assign held_base  = HAW'(slot_r * MAX_HELD);
  assign held_raddr = held_base + HAW'(i_r);
  assign esrc_raddr = (cmd.op == OP_P_J) ? j_r[EAW-1:0] : k_r[EAW-1:0];
  assign out_free   = !out_valid_r || out_tready;
  assign e_keep     = (esrc_rdata != lid_r) && (etgt_rdata != lid_r);

  assign sts.t_lt       = t_r < slots_used_r;
  assign sts.t_hit      = thr_rdata == tid_r;
  assign sts.slots_full = slots_used_r == TCW'(MAX_THREADS);
  assign sts.h_lt       = i_r < cnt_r;
  assign sts.h_self     = held_rdata == lid_r;
  assign sts.e_lt       = k_r < eu_r;
  assign sts.e_dup      = (esrc_rdata == src_r) && (etgt_rdata == lid_r);
  assign sts.pass_go    = changed_r && (left_r != '0);
  assign sts.j_lt       = j_r < eu_r;
  assign sts.gone_j     = gone_r[j_r[EAW-1:0]];
  assign sts.gone_k     = gone_r[k_r[EAW-1:0]];
  assign sts.t_in       = etgt_rdata == src_r;
  assign sts.kind       = kind_r;
  assign sts.out_free   = out_free;

  always_comb begin
    thr_we     = 1'b0;
    thr_waddr  = slots_used_r[TAW-1:0];
    cnt_we     = 1'b0;
    cnt_waddr  = slot_r;
    cnt_wdata  = '0;
    held_we    = 1'b0;
    held_waddr = held_base + HAW'(cnt_r);
    held_wdata = lid_r;
    edge_we    = 1'b0;
    edge_waddr = eu_r[EAW-1:0];
    esrc_wdata = src_r;
    etgt_wdata = lid_r;
    case (cmd.op)
      OP_ALLOC: begin
        thr_we    = 1'b1;
        cnt_we    = 1'b1;
        cnt_waddr = slots_used_r[TAW-1:0];
      end
      OP_E_ADD: edge_we = eu_r != ECW'(MAX_EDGES);
      OP_APPEND: begin
        held_we   = cnt_r != HCW'(MAX_HELD);
        cnt_we    = held_we;
        cnt_wdata = cnt_r + 1'b1;
      end
      OP_U_HRD: begin
        cnt_we    = !sts.h_lt;
        cnt_wdata = hkeep_r;
      end
      OP_U_HCMP: begin
        held_we    = !sts.h_self;
        held_waddr = held_base + HAW'(hkeep_r);
        held_wdata = held_rdata;
      end
      OP_U_ECMP: begin
        edge_we    = e_keep;
        edge_waddr = ekeep_r[EAW-1:0];
        esrc_wdata = esrc_rdata;
        etgt_wdata = etgt_rdata;
      end
      default: ;
    endcase
  end

  lodd_ram #(.W(32), .D(MAX_THREADS)) u_thr_ram (
    .clk(clk), .we(thr_we), .waddr(thr_waddr), .wdata(tid_r),
    .raddr(t_r[TAW-1:0]), .rdata(thr_rdata)
  );

  lodd_ram #(.W(HCW), .D(MAX_THREADS)) u_cnt_ram (
    .clk(clk), .we(cnt_we), .waddr(cnt_waddr), .wdata(cnt_wdata),
    .raddr(slot_r), .rdata(cnt_rdata)
  );

  lodd_ram #(.W(32), .D(MAX_THREADS * MAX_HELD)) u_held_ram (
    .clk(clk), .we(held_we), .waddr(held_waddr), .wdata(held_wdata),
    .raddr(held_raddr), .rdata(held_rdata)
  );

  lodd_ram #(.W(32), .D(MAX_EDGES)) u_esrc_ram (
    .clk(clk), .we(edge_we), .waddr(edge_waddr), .wdata(esrc_wdata),
    .raddr(esrc_raddr), .rdata(esrc_rdata)
  );

  lodd_ram #(.W(32), .D(MAX_EDGES)) u_etgt_ram (
    .clk(clk), .we(edge_we), .waddr(edge_waddr), .wdata(etgt_wdata),
    .raddr(k_r[EAW-1:0]), .rdata(etgt_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slots_used_r <= '0;
      eu_r         <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (out_valid_r && out_tready && cmd.op != OP_FIN) begin
        out_valid_r <= 1'b0;
      end
      case (cmd.op)
        OP_IDLE: begin
          if (in_tvalid) begin
            kind_r     <= in_tuser;
            tid_r      <= in_tdata[31:0];
            lid_r      <= in_tdata[63:32];
            t_r        <= '0;
            status_r   <= ST_OK;
            deadlock_r <= 1'b0;
          end
        end
        OP_T_RD: begin
          if (!sts.t_lt && sts.slots_full) status_r <= ST_THR_FULL;
        end
        OP_T_CMP: begin
          if (sts.t_hit) slot_r <= t_r[TAW-1:0];
          else t_r <= t_r + 1'b1;
        end
        OP_ALLOC: begin
          slot_r       <= slots_used_r[TAW-1:0];
          slots_used_r <= slots_used_r + 1'b1;
          cnt_r        <= '0;
          i_r          <= '0;
          hkeep_r      <= '0;
          k_r          <= '0;
          ekeep_r      <= '0;
        end
        OP_C_LD: begin
          cnt_r   <= cnt_rdata;
          i_r     <= '0;
          hkeep_r <= '0;
          k_r     <= '0;
          ekeep_r <= '0;
        end
        OP_L_HLD: begin
          src_r <= held_rdata;
          if (sts.h_self) i_r <= i_r + 1'b1;
          else k_r <= '0;
        end
        OP_E_CMP: begin
          if (sts.e_dup) i_r <= i_r + 1'b1;
          else k_r <= k_r + 1'b1;
        end
        OP_E_ADD: begin
          if (eu_r == ECW'(MAX_EDGES)) status_r <= ST_EDGE_FULL;
          else eu_r <= eu_r + 1'b1;
          i_r <= i_r + 1'b1;
        end
        OP_P_INIT: begin
          gone_r    <= '0;
          left_r    <= eu_r;
          changed_r <= 1'b1;
        end
        OP_P_PASS: begin
          if (sts.pass_go) begin
            changed_r <= 1'b0;
            j_r       <= '0;
          end else begin
            deadlock_r <= left_r != '0;
          end
        end
        OP_P_J: begin
          if (sts.j_lt && sts.gone_j) j_r <= j_r + 1'b1;
        end
        OP_P_JLD: begin
          src_r <= esrc_rdata;
          k_r   <= '0;
        end
        OP_P_IRD: begin
          if (sts.e_lt) begin
            if (sts.gone_k) k_r <= k_r + 1'b1;
          end else begin
            gone_r[j_r[EAW-1:0]] <= 1'b1;
            left_r    <= left_r - 1'b1;
            changed_r <= 1'b1;
            j_r       <= j_r + 1'b1;
          end
        end
        OP_P_ICMP: begin
          if (sts.t_in) j_r <= j_r + 1'b1;
          else k_r <= k_r + 1'b1;
        end
        OP_APPEND: begin
          if (cnt_r == HCW'(MAX_HELD)) status_r <= ST_HELD_FULL;
        end
        OP_U_HCMP: begin
          if (!sts.h_self) hkeep_r <= hkeep_r + 1'b1;
          i_r <= i_r + 1'b1;
        end
        OP_U_ERD: begin
          if (!sts.e_lt) eu_r <= ekeep_r;
        end
        OP_U_ECMP: begin
          if (e_keep) ekeep_r <= ekeep_r + 1'b1;
          k_r <= k_r + 1'b1;
        end
        OP_FIN: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_data_r  <= {6'd0, 7'(eu_r), status_r, deadlock_r};
          end
        end
        default: ;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

### hdl/lodd_checker.sv
// ----------------------------------------------------------------------------
// lodd_checker
// port level checks on the detector, bound to the top level
// ----------------------------------------------------------------------------
module lodd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [63:0] in_tdata,
  input logic        in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  a_no_out_after_rst: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request taken while busy");

  a_fill_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[15:10] == 6'd0)
    else $error("nonzero fill bits");

  a_full_no_deadlock: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[0] |-> out_tdata[2:1] != 2'd1)
    else $error("deadlock on an ignored request");

endmodule

bind lock_order_deadlock_detector_top lodd_checker u_lodd_checker (.*);
